@@ design/tam_pkg.sv @@
// Package for the triangle adjacency edge matcher: payload types, codes,
// state machine encoding and the controller/datapath command structs.
// No dependencies.
package tam_pkg;

  localparam int EDGE_SLOTS    = 4096;
  localparam int MAX_TRIANGLES = 65536;
  localparam int IDX_W         = $clog2(EDGE_SLOTS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int TRI_W         = 17;
  localparam int VERT_W        = 16;
  localparam int KEY_W         = 2 * VERT_W;

  // request command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // result status codes
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_LIMIT  = 2'd3;

  // edge slot codes
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;
  } tam_in_t;

  typedef struct packed {
    logic [15:0] this_triangle;
    logic [1:0]  edge_slot;
    logic [1:0]  status;
    logic [15:0] neighbour_triangle;
    logic        last_result;
  } tam_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_PROBE,
    S_COMMIT
  } tam_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic clear;       // empty store, restart numbering
    logic probe_start; // rewind scan for the current edge
    logic probe_step;  // advance scan by one entry
    logic commit;      // emit edge result, insert on miss
    logic limit;       // emit triangle limit result
  } tam_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic at_limit;
    logic probe_done;
    logic last_edge;
    logic out_free;
  } tam_sts_t;

endpackage

@@ design/tam_ctrl.sv @@
// Controller of the triangle adjacency edge matcher: sequences load,
// per-edge scan and result commit. Depends on tam_pkg.
module tam_ctrl import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tam_sts_t sts,
  output tam_cmd_t cmd
);

  tam_state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.is_clear) begin
          state_nxt = S_IDLE;
        end else if (sts.at_limit) begin
          state_nxt = S_LIMIT;
        end else if (sts.probe_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_LIMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_edge ? S_IDLE : S_PROBE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready         = 1'b1;
        cmd.load         = in_valid;
        cmd.probe_start  = in_valid;
      end
      S_PROBE: begin
        cmd.clear      = sts.is_clear;
        cmd.probe_step = !sts.is_clear && !sts.at_limit;
      end
      S_LIMIT: begin
        cmd.limit = sts.out_free;
      end
      S_COMMIT: begin
        cmd.commit      = sts.out_free;
        cmd.probe_start = sts.out_free && !sts.last_edge;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/tam_dp.sv @@
// Datapath of the triangle adjacency edge matcher: request registers,
// edge memory with linear scan, counters and the result register.
// Depends on tam_pkg.
module tam_dp import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tam_in_t  in_data,
  input  tam_cmd_t cmd,
  output tam_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output tam_out_t out_data
);

  logic [KEY_W+15:0] mem [EDGE_SLOTS];
  logic [KEY_W+15:0] mem_q_r;

  tam_in_t           req_r;
  logic [1:0]        edge_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TRI_W-1:0]  tri_r;
  logic [CNT_W-1:0]  addr_r;
  logic              pend_r;
  logic              hit_r;
  logic [15:0]       owner_r;
  logic              out_valid_r;
  tam_out_t          out_r;

  logic [VERT_W-1:0] p, q;
  logic [KEY_W-1:0]  rev_key, fwd_key;
  logic              key_hit, scan_end, done;
  logic              room;

  // pick the directed edge of the current slot
  always_comb begin
    case (edge_r)
      EDGE_AB: begin p = req_r.vert_a; q = req_r.vert_b; end
      EDGE_BC: begin p = req_r.vert_b; q = req_r.vert_c; end
      default: begin p = req_r.vert_c; q = req_r.vert_a; end
    endcase
  end

  // stop once the entry in flight matches or every filled slot has been compared
  assign rev_key  = {q, p};
  assign fwd_key  = {p, q};
  assign key_hit  = pend_r && (mem_q_r[KEY_W+15:16] == rev_key);
  assign scan_end = addr_r >= cnt_r;
  assign done     = key_hit || scan_end;
  assign room     = cnt_r < CNT_W'(EDGE_SLOTS);

  assign sts.is_clear   = req_r.cmd == CMD_CLEAR;
  assign sts.at_limit   = tri_r >= TRI_W'(MAX_TRIANGLES);
  assign sts.probe_done = done;
  assign sts.last_edge  = edge_r == EDGE_CA;
  assign sts.out_free   = !out_valid_r || out_ready;

  // edge memory: one scan read, one insert write
  always_ff @(posedge clk) begin
    if (cmd.probe_step && !done) begin
      mem_q_r <= mem[addr_r[IDX_W-1:0]];
    end
    if (cmd.commit && !hit_r && room) begin
      mem[cnt_r[IDX_W-1:0]] <= {fwd_key, tri_r[15:0]};
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.probe_step && done) begin
      hit_r   <= key_hit;
      owner_r <= mem_q_r[15:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      tri_r       <= '0;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      edge_r      <= EDGE_AB;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
        tri_r <= '0;
      end
      if (cmd.probe_step) begin
        pend_r <= !done;
        if (!done) begin
          addr_r <= addr_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        if (!hit_r && room) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (edge_r == EDGE_CA) begin
          tri_r <= tri_r + 1'b1;
        end
        edge_r <= edge_r + 2'd1;
      end
      if (cmd.load) begin
        edge_r <= EDGE_AB;
      end
      if (cmd.probe_start) begin
        addr_r <= '0;
        pend_r <= 1'b0;
      end
      if (cmd.commit || cmd.limit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.limit) begin
      out_r.this_triangle      <= tri_r[15:0];
      out_r.edge_slot          <= EDGE_AB;
      out_r.status             <= ST_LIMIT;
      out_r.neighbour_triangle <= '0;
      out_r.last_result        <= 1'b1;
    end else if (cmd.commit) begin
      out_r.this_triangle      <= tri_r[15:0];
      out_r.edge_slot          <= edge_r;
      out_r.status             <= hit_r ? ST_MATCH : (room ? ST_STORED : ST_FULL);
      out_r.neighbour_triangle <= hit_r ? owner_r : 16'd0;
      out_r.last_result        <= edge_r == EDGE_CA;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(EDGE_SLOTS))
    else $error("edge count beyond store size");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.limit) |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (cnt_r == '0 && tri_r == '0))
    else $error("clear did not empty store");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (addr_r <= cnt_r))
    else $error("scan read past filled slots");

endmodule

@@ design/triangle_adjacency_edge_matcher.sv @@
// Top level of the triangle adjacency edge matcher: joins controller and
// datapath. Depends on tam_pkg, tam_ctrl, tam_dp.
//
//   channel | ports                          | carries
//   in      | in_valid, in_ready, in_data    | command and three vertices
//   out     | out_valid, out_ready, out_data | one result per edge, or one limit result
//
// An add request scans the edge memory once per edge, one entry a cycle,
// stopping early on a hit; a clear empties the store and gives no result,
// and a request at the triangle limit gives a single limit result.
// The single read port of the edge memory sets the scan pace.
// Reset empties the store at once through the fill count; no sweep runs.
// A stalled output holds the controller before the next result is loaded.
module triangle_adjacency_edge_matcher import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tam_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tam_out_t out_data
);

  tam_cmd_t cmd;
  tam_sts_t sts;

  tam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tam_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tam_checker.sv @@
// Result checker for the triangle adjacency edge matcher: watches both
// channels, predicts each request's edge results and compares them in order.
// Depends on tam_pkg.
module tam_checker import tam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  tam_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  tam_out_t out_data,
  output int       errors,
  output int       pending,
  output int       results_seen,
  output int       hits_seen,
  output int       full_seen,
  output int       limit_seen
);

  localparam int REPORT_CAP = 40;

  // predicted store: slots below fill are the valid ones
  logic [KEY_W-1:0]  key_mem [EDGE_SLOTS];
  logic [15:0]       owner_mem [EDGE_SLOTS];
  int unsigned       fill;
  logic [TRI_W-1:0]  tri_num;
  tam_out_t          expected_edges[$];

  // Search the predicted store, lowest slot first
  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < fill; i++) begin
      if (key_mem[i] == key) return i;
    end
    return -1;
  endfunction

  // Work out the results of one request and update the predicted store
  task automatic predict_edges(input tam_in_t req);
    logic [VERT_W-1:0] vtx[3];
    logic [VERT_W-1:0] p, q;
    tam_out_t          res;
    int                hit;
    if (req.cmd == CMD_CLEAR) begin
      fill    = 0;
      tri_num = '0;
      return;
    end
    vtx[0] = req.vert_a;
    vtx[1] = req.vert_b;
    vtx[2] = req.vert_c;
    if (tri_num >= MAX_TRIANGLES) begin
      res = '{this_triangle: tri_num[15:0], edge_slot: EDGE_AB, status: ST_LIMIT,
              neighbour_triangle: '0, last_result: 1'b1};
      expected_edges.push_back(res);
      return;
    end
    for (int j = 0; j < 3; j++) begin
      p = vtx[j];
      q = vtx[(j + 1) % 3];
      res.this_triangle      = tri_num[15:0];
      res.edge_slot          = 2'(j);
      res.neighbour_triangle = '0;
      res.last_result        = (j == 2);
      hit = find_slot({q, p});
      if (hit >= 0) begin
        res.status             = ST_MATCH;
        res.neighbour_triangle = owner_mem[hit];
      end else if (fill < EDGE_SLOTS) begin
        key_mem[fill]   = {p, q};
        owner_mem[fill] = tri_num[15:0];
        fill++;
        res.status = ST_STORED;
      end else begin
        res.status = ST_FULL;
      end
      expected_edges.push_back(res);
    end
    tri_num = tri_num + 1'b1;
  endtask

  task automatic flag(input string name, input int exp_v, input int got_v);
    errors++;
    if (errors <= REPORT_CAP)
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    hits_seen = 0;
    full_seen = 0;
    limit_seen = 0;
    fill = 0;
    tri_num = '0;
  end

  assign pending = expected_edges.size();

  // Predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    tam_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_edges(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_edges.size() == 0) begin
          errors++;
          $error("unexpected result for triangle %0d", out_data.this_triangle);
        end else begin
          want = expected_edges.pop_front();
          if (out_data.this_triangle != want.this_triangle)
            flag("this_triangle", want.this_triangle, out_data.this_triangle);
          if (out_data.edge_slot != want.edge_slot)
            flag("edge_slot", want.edge_slot, out_data.edge_slot);
          if (out_data.status != want.status)
            flag("status", want.status, out_data.status);
          if (out_data.neighbour_triangle != want.neighbour_triangle)
            flag("neighbour_triangle", want.neighbour_triangle,
                 out_data.neighbour_triangle);
          if (out_data.last_result != want.last_result)
            flag("last_result", want.last_result, out_data.last_result);
          case (want.status)
            ST_MATCH: hits_seen++;
            ST_FULL:  full_seen++;
            ST_LIMIT: limit_seen++;
            default: ;
          endcase
        end
      end
    end
  end

endmodule

@@ tb/triangle_adjacency_edge_matcher_test.sv @@
// Testbench top for the triangle adjacency edge matcher: drives requests,
// paces the result channel and gives the verdict.
// Depends on tam_pkg, tam_checker and the design under test.
module triangle_adjacency_edge_matcher_test;
  import tam_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tam_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tam_out_t out_data;

  int errors, pending, results_seen, hits_seen, full_seen, limit_seen;
  int requests_sent;
  bit bursty;
  bit hold_req;
  int burst_left;

  triangle_adjacency_edge_matcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tam_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .hits_seen(hits_seen), .full_seen(full_seen), .limit_seen(limit_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #300000000;
    $display("triangle_adjacency_edge_matcher_test failed");
    $finish;
  end

  // Offer one request and hold it until accepted; pause between bursts
  task automatic offer(input tam_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 8);
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic add_tri(input logic [15:0] a, input logic [15:0] b,
                         input logic [15:0] c);
    offer('{cmd: CMD_ADD, vert_a: a, vert_b: b, vert_c: c});
  endtask

  task automatic clear_mesh();
    offer('{cmd: CMD_CLEAR, vert_a: 16'($urandom), vert_b: 16'($urandom),
            vert_c: 16'($urandom)});
  endtask

  // Pick a vertex: mostly from a small pool so edges meet, sometimes any value
  function automatic logic [15:0] pick_vertex();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 9));
  endfunction

  // Result channel: long hold-off on request, else alternate ready and choppy
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
        hold_req = 1'b0;
      end else if (!bursty || (phase % 100) < 40) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  initial begin
    logic [15:0] pa, pb, pc;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    bursty = 1'b1;
    hold_req = 1'b0;
    burst_left = 0;
    requests_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stores, matches, duplicate keys, same-triangle match, extremes
    add_tri(1, 2, 3);
    add_tri(2, 1, 3);
    add_tri(1, 2, 4);
    add_tri(2, 1, 9);
    add_tri(5, 6, 5);
    add_tri(0, 16'hFFFF, 0);
    add_tri(16'hFFFF, 0, 16'hFFFF);
    add_tri(16'hAAAA, 16'h5555, 16'h0F0F);
    add_tri(16'h5555, 16'hAAAA, 16'hF0F0);
    offer('{cmd: CMD_CLEAR, vert_a: 16'hFFFF, vert_b: 16'hFFFF, vert_c: 16'hFFFF});
    add_tri(2, 1, 3);
    clear_mesh();
    add_tri(3, 2, 1);

    // Random meshes: mostly neighbouring triangles, some noise and clears
    hold_req = 1'b1;
    pa = 1; pb = 2; pc = 3;
    for (int n = 0; n < 440; n++) begin
      case ($urandom_range(0, 19))
        0: clear_mesh();
        1, 2, 3: begin
          pa = 16'($urandom); pb = 16'($urandom); pc = 16'($urandom);
          add_tri(pa, pb, pc);
        end
        4, 5, 6, 7, 8, 9, 10: begin
          // share an edge with the previous triangle, reversed
          {pa, pb, pc} = {pb, pa, pick_vertex()};
          add_tri(pa, pb, pc);
        end
        default: begin
          pa = pick_vertex(); pb = pick_vertex(); pc = pick_vertex();
          add_tri(pa, pb, pc);
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain, then let a trailing clear settle
    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);

    $display("Sent %0d requests; %0d results checked", requests_sent, results_seen);
    $display("Matches %0d, store-full %0d, triangle-limit %0d",
             hits_seen, full_seen, limit_seen);
    if (errors == 0 && pending == 0) begin
      $display("triangle_adjacency_edge_matcher_test passed");
    end else begin
      $display("triangle_adjacency_edge_matcher_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tam_pkg.sv
design/tam_ctrl.sv
design/tam_dp.sv
design/triangle_adjacency_edge_matcher.sv
tb/tam_checker.sv
tb/triangle_adjacency_edge_matcher_test.sv
